FILE: rtl/core/scf_pkg.sv
// ---------------------------------------------------------------------------
// Sliding correlation FIR package
// Shared widths, defaults and request codes for the correlation filter.
// ---------------------------------------------------------------------------
package scf_pkg;

	localparam int MAX_TAPS_DEF    = 32;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int TAP_CNT_W       = 6;
	localparam int TAP_IDX_W       = 5;
	localparam int SUM_W           = 37;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

endpackage

FILE: rtl/core/scf_item_if.sv
// ---------------------------------------------------------------------------
// Input request channel
// Valid/ready channel carrying one sample push or coefficient load.
// ---------------------------------------------------------------------------
interface scf_item_if #(
	parameter int SAMPLE_BITS = scf_pkg::SAMPLE_BITS_DEF
);
	logic                                 valid;
	logic                                 ready;
	logic                                 func;
	logic [scf_pkg::TAP_IDX_W-1:0]        tap_index;
	logic signed [SAMPLE_BITS-1:0]        value;
	logic                                 start_of_vector;

	modport source (output valid, func, tap_index, value, start_of_vector, input ready);
	modport sink   (input valid, func, tap_index, value, start_of_vector, output ready);
endinterface

FILE: rtl/core/scf_result_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one Q.30 correlation sum.
// ---------------------------------------------------------------------------
interface scf_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [scf_pkg::SUM_W-1:0] sum;

	modport source (output valid, sum, input ready);
	modport sink   (input valid, sum, output ready);
endinterface

FILE: rtl/core/scf_cfg_if.sv
// ---------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the tap count register write data.
// ---------------------------------------------------------------------------
interface scf_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [scf_pkg::TAP_CNT_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/sliding_correlation_fir.sv
// ---------------------------------------------------------------------------
// Sliding correlation FIR
// A sample that completes a window is summed by the single multiply-accumulate
// walking the taps (RUN), drained (DRAIN) and registered out (OUT), which waits
// while the previous sum is untaken; requests are taken only in idle. Loads and
// short-window samples stay idle. Reset clears control state, sets tap_count to
// 1; the sample and tap RAMs are not cleared, the fill count gates window reads.
// ---------------------------------------------------------------------------
module sliding_correlation_fir #(
	parameter int MAX_TAPS    = scf_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = scf_pkg::SAMPLE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	scf_cfg_if.sink          cfg,
	scf_item_if.sink         item,
	scf_result_if.source     result
);
	import scf_pkg::*;

	localparam int AW      = $clog2(MAX_TAPS);
	localparam int CW      = ($clog2(MAX_TAPS + 1) > TAP_CNT_W) ?
	                         $clog2(MAX_TAPS + 1) : TAP_CNT_W;
	localparam int PROD_W  = 2 * SAMPLE_BITS;
	localparam int ACC_RAW = PROD_W + $clog2(MAX_TAPS) + 1;
	localparam int ACC_W   = (ACC_RAW > SUM_W) ? ACC_RAW : SUM_W;

	localparam logic [CW-1:0]         MAX_C   = CW'(MAX_TAPS);
	localparam logic [AW:0]           DEPTH_E = (AW + 1)'(MAX_TAPS);
	localparam logic [AW-1:0]         LAST_A  = AW'(MAX_TAPS - 1);
	localparam logic signed [ACC_W-1:0] SUM_HI =
		ACC_W'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SUM_LO = -SUM_HI - ACC_W'(1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [TAP_CNT_W-1:0]     tap_count_q;
	logic [CW-1:0]            taps;
	logic [CW-1:0]            tc_ext;
	logic [CW-1:0]            taps_m1;
	logic [1:0]               state_q;
	logic [CW-1:0]            fill_q;
	logic [CW-1:0]            fill_new;
	logic [AW-1:0]            wp_q;
	logic [AW-1:0]            wp_new;
	logic [AW:0]              start_sum;
	logic [AW-1:0]            start_a;
	logic [CW-1:0]            step_q;
	logic [AW-1:0]            rd_a_q;
	logic                     v_s1;
	logic                     v_s2;
	logic [SAMPLE_BITS-1:0]   win_rd_s1;
	logic [SAMPLE_BITS-1:0]   coef_rd_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_sat;
	logic                     res_valid_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     fire;
	logic                     push;
	logic                     load;
	logic                     idx_ok;

	assign cfg.ready  = 1'b1;
	assign item.ready = (state_q == ST_IDLE);
	assign fire       = item.valid && item.ready;
	assign push       = fire && (item.func == FUNC_PUSH);
	assign idx_ok     = int'(item.tap_index) < MAX_TAPS;
	assign load       = fire && (item.func == FUNC_LOAD) && idx_ok;

	assign result.valid = res_valid_q;
	assign result.sum   = sum_q;

	// Clamp the register to the supported tap range
	always_comb begin
		tc_ext = CW'(tap_count_q);
		if (tc_ext == '0) begin
			taps = CW'(1);
		end else if (tc_ext > MAX_C) begin
			taps = MAX_C;
		end else begin
			taps = tc_ext;
		end
		taps_m1 = taps - CW'(1);
	end

	always_comb begin
		wp_new = (wp_q == LAST_A) ? '0 : wp_q + AW'(1);
		if (item.start_of_vector) begin
			fill_new = CW'(1);
		end else if (fill_q < MAX_C) begin
			fill_new = fill_q + CW'(1);
		end else begin
			fill_new = fill_q;
		end
		// Oldest sample of the window, modulo the ring depth
		start_sum = {1'b0, wp_new} + DEPTH_E - {1'b0, taps_m1[AW-1:0]};
		if (start_sum >= DEPTH_E) begin
			start_a = AW'(start_sum - DEPTH_E);
		end else begin
			start_a = start_sum[AW-1:0];
		end
	end

	always_comb begin
		if (acc_q > SUM_HI) begin
			acc_sat = SUM_HI;
		end else if (acc_q < SUM_LO) begin
			acc_sat = SUM_LO;
		end else begin
			acc_sat = acc_q;
		end
	end

	scf_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_TAPS)
	) u_window (
		.clk   (clk),
		.we    (push),
		.waddr (wp_new),
		.wdata (item.value),
		.raddr (rd_a_q),
		.rdata (win_rd_s1)
	);

	scf_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_TAPS)
	) u_coef (
		.clk   (clk),
		.we    (load),
		.waddr (AW'(item.tap_index)),
		.wdata (item.value),
		.raddr (step_q[AW-1:0]),
		.rdata (coef_rd_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_CNT_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			tap_count_q <= cfg.data;
		end
	end

	// Product stage, no reset on payload
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(win_rd_s1) * $signed(coef_rd_s1);
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			wp_q        <= '0;
			step_q      <= '0;
			rd_a_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
			sum_q       <= '0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
			// the output state reloads the result itself when one is taken
			if (result.valid && result.ready && (state_q != ST_OUT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (push) begin
						wp_q   <= wp_new;
						fill_q <= fill_new;
						if (fill_new >= taps) begin
							step_q  <= '0;
							rd_a_q  <= start_a;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					step_q <= step_q + CW'(1);
					rd_a_q <= (rd_a_q == LAST_A) ? '0 : rd_a_q + AW'(1);
					if (step_q == taps_m1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// hold until the last product is in the accumulator
					if (!v_s1 && !v_s2) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_valid_q || result.ready) begin
						sum_q       <= SUM_W'(acc_sat);
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> (!v_s1 && !v_s2))
		else $error("request taken while the multiply pipeline is busy");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q < taps))
		else $error("tap step beyond the taps in use");

	a_fill_sat: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= MAX_C)
		else $error("fill count beyond window depth");

	a_out_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (!v_s1 && !v_s2))
		else $error("sum released before accumulation finished");

endmodule

FILE: rtl/core/scf_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module scf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
